// File: hw/rtl/bbk_pkg.sv
package bbk_pkg;

  localparam int SCORE_W = 32;
  localparam int DATA_W  = 64;
  localparam int OCC_W   = 7;
  localparam int RIDX_W  = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic signed [DATA_W-1:0]  z;
  } entry_t;

  // outcome of one compare step of the sift unit
  typedef struct packed {
    logic pick_right;
    logic swap;
  } cmp_res_t;

endpackage

// File: hw/rtl/bbk_if.sv
interface bbk_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         read_index;
  logic signed [63:0] new_x;
  logic signed [63:0] new_y;
  logic signed [63:0] new_z;
  logic signed [31:0] new_score;

  modport source (
    output valid, operation, read_index, new_x, new_y, new_z, new_score,
    input  ready
  );
  modport sink (
    input  valid, operation, read_index, new_x, new_y, new_z, new_score,
    output ready
  );
endinterface

interface bbk_out_if;
  logic               valid;
  logic               ready;
  logic               stored;
  logic [6:0]         occupancy;
  logic               read_valid;
  logic signed [63:0] out_x;
  logic signed [63:0] out_y;
  logic signed [63:0] out_z;
  logic signed [31:0] out_score;

  modport source (
    output valid, stored, occupancy, read_valid, out_x, out_y, out_z, out_score,
    input  ready
  );
  modport sink (
    input  valid, stored, occupancy, read_valid, out_x, out_y, out_z, out_score,
    output ready
  );
endinterface

// File: hw/rtl/bbk_ram.sv
module bbk_ram
  import bbk_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  output entry_t        ra_data,
  output entry_t        rb_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// File: hw/rtl/bbk_cmp.sv
module bbk_cmp
  import bbk_pkg::*;
(
  input  logic signed [SCORE_W-1:0] cur_score,
  input  logic signed [SCORE_W-1:0] left_score,
  input  logic signed [SCORE_W-1:0] right_score,
  input  logic                      has_right,
  output cmp_res_t                  res
);

  logic signed [SCORE_W-1:0] big_score;

  always_comb begin
    // ties go to the left child
    res.pick_right = has_right && (left_score < right_score);
    big_score      = res.pick_right ? right_score : left_score;
    res.swap       = cur_score < big_score;
  end

endmodule

// File: hw/rtl/bounded_best_k_heap_top.sv
// one item at a time; the next input can be taken in the same cycle its result goes valid
// read: the entry is read in idle and captured in the read-out state; insert while filling: written in idle
// replacing insert: root compare, then one sift step per heap level visited by the single compare unit;
// dropped candidate: root compare only; every result then waits in the done state until the output is free
// insert that fills the store: bottom-up build, load node, load kids, then sift, for each parent
// reset clears the fill count, sequencer and output valid; the entry memory is not cleared
module bounded_best_k_heap_top
  import bbk_pkg::*;
#(
  parameter int HEAP_SIZE = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  bbk_in_if.sink       in_ch,
  bbk_out_if.source    out_ch
);

  localparam int AW = $clog2(HEAP_SIZE);
  localparam int KW = AW + 1;
  localparam int FW = $clog2(HEAP_SIZE + 1);
  localparam int CW = (FW > RIDX_W) ? FW : RIDX_W;
  localparam logic [KW-1:0] LAST_K      = KW'(HEAP_SIZE - 1);
  localparam logic [AW-1:0] LAST_A      = AW'(HEAP_SIZE - 1);
  localparam logic [AW-1:0] LAST_PARENT = AW'((HEAP_SIZE - 1) / 2);
  localparam logic [FW-1:0] FULL        = FW'(HEAP_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_CMP,
    ST_LOAD_NODE,
    ST_LOAD_KIDS,
    ST_SIFT,
    ST_READ_OUT,
    ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          build_r, build_nxt;
  logic [AW-1:0] bidx_r, bidx_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [KW-1:0] kid_r, kid_nxt;
  entry_t        cur_r, cur_nxt;
  logic          res_stored_r, res_stored_nxt;
  logic          res_rvalid_r, res_rvalid_nxt;
  entry_t        res_entry_r, res_entry_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic          o_stored_r;
  logic [OCC_W-1:0] o_occ_r;
  logic          o_rvalid_r;
  entry_t        o_entry_r;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] ra_addr, rb_addr;
  entry_t        ra_data, rb_data;
  entry_t        cand;
  entry_t        big;
  logic [AW-1:0] big_idx;
  logic [KW-1:0] kid_new;
  logic signed [SCORE_W-1:0] cmp_cur;
  logic          cmp_has_right;
  cmp_res_t      cmp;
  logic          out_free;
  logic          finish;

  function automatic logic [AW-1:0] clamp_addr(input logic [KW-1:0] k);
    if (k > LAST_K) begin
      return LAST_A;
    end
    return k[AW-1:0];
  endfunction

  bbk_ram #(
    .DEPTH (HEAP_SIZE),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // one compare unit serves the root test and every sift level
  bbk_cmp u_cmp (
    .cur_score   (cmp_cur),
    .left_score  (ra_data.score),
    .right_score (rb_data.score),
    .has_right   (cmp_has_right),
    .res         (cmp)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = ovalid_r;
  assign out_ch.stored     = o_stored_r;
  assign out_ch.occupancy  = o_occ_r;
  assign out_ch.read_valid = o_rvalid_r;
  assign out_ch.out_x      = o_entry_r.x;
  assign out_ch.out_y      = o_entry_r.y;
  assign out_ch.out_z      = o_entry_r.z;
  assign out_ch.out_score  = o_entry_r.score;

  assign out_free = !ovalid_r || out_ch.ready;

  assign cmp_cur       = cur_r.score;
  assign cmp_has_right = (state_r == ST_SIFT) && (kid_r < LAST_K);

  always_comb begin
    cand.score = in_ch.new_score;
    cand.x     = in_ch.new_x;
    cand.y     = in_ch.new_y;
    cand.z     = in_ch.new_z;

    state_nxt      = state_r;
    fill_nxt       = fill_r;
    build_nxt      = build_r;
    bidx_nxt       = bidx_r;
    node_nxt       = node_r;
    kid_nxt        = kid_r;
    cur_nxt        = cur_r;
    res_stored_nxt = res_stored_r;
    res_rvalid_nxt = res_rvalid_r;
    res_entry_nxt  = res_entry_r;
    ovalid_nxt     = ovalid_r && !out_ch.ready;

    we            = 1'b0;
    waddr         = node_r;
    wdata         = cur_r;
    ra_addr       = '0;
    rb_addr       = '0;
    finish        = 1'b0;
    kid_new       = '0;
    big           = cmp.pick_right ? rb_data : ra_data;
    big_idx       = cmp.pick_right ? AW'(kid_r + 1'b1) : kid_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_entry_nxt = '0;
          if (in_ch.operation == OP_READ) begin
            ra_addr        = AW'(in_ch.read_index);
            res_rvalid_nxt = CW'(in_ch.read_index) < CW'(fill_r);
            res_stored_nxt = 1'b0;
            state_nxt      = ST_READ_OUT;
          end else if (fill_r != FULL) begin
            we             = 1'b1;
            waddr          = AW'(fill_r);
            wdata          = cand;
            fill_nxt       = fill_r + 1'b1;
            res_stored_nxt = 1'b1;
            res_rvalid_nxt = 1'b0;
            if (fill_r == FULL - 1'b1) begin
              build_nxt = 1'b1;
              bidx_nxt  = LAST_PARENT;
              state_nxt = ST_LOAD_NODE;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            ra_addr        = '0;
            cur_nxt        = cand;
            res_rvalid_nxt = 1'b0;
            state_nxt      = ST_ROOT_CMP;
          end
        end
      end
      ST_ROOT_CMP: begin
        // candidate kept only when strictly below the root score
        if (cmp.swap) begin
          res_stored_nxt = 1'b1;
          node_nxt       = '0;
          kid_nxt        = KW'(1);
          ra_addr        = clamp_addr(KW'(1));
          rb_addr        = clamp_addr(KW'(2));
          state_nxt      = ST_SIFT;
        end else begin
          res_stored_nxt = 1'b0;
          state_nxt      = ST_DONE;
        end
      end
      ST_LOAD_NODE: begin
        ra_addr   = bidx_r;
        state_nxt = ST_LOAD_KIDS;
      end
      ST_LOAD_KIDS: begin
        kid_new   = {bidx_r, 1'b1};
        cur_nxt   = ra_data;
        node_nxt  = bidx_r;
        kid_nxt   = kid_new;
        ra_addr   = clamp_addr(kid_new);
        rb_addr   = clamp_addr(KW'(kid_new + 1'b1));
        state_nxt = ST_SIFT;
      end
      ST_SIFT: begin
        we    = 1'b1;
        waddr = node_r;
        if (kid_r <= LAST_K && cmp.swap) begin
          // larger child moves up, the carried entry keeps sinking
          wdata    = big;
          kid_new  = {big_idx, 1'b1};
          node_nxt = big_idx;
          kid_nxt  = kid_new;
          ra_addr  = clamp_addr(kid_new);
          rb_addr  = clamp_addr(KW'(kid_new + 1'b1));
        end else begin
          wdata  = cur_r;
          finish = 1'b1;
        end
        if (finish) begin
          if (build_r && bidx_r != '0) begin
            bidx_nxt  = bidx_r - 1'b1;
            state_nxt = ST_LOAD_NODE;
          end else begin
            build_nxt = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ_OUT: begin
        res_entry_nxt = res_rvalid_r ? ra_data : '0;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      build_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      build_r  <= build_nxt;
      ovalid_r <= ovalid_nxt;
    end
    bidx_r       <= bidx_nxt;
    node_r       <= node_nxt;
    kid_r        <= kid_nxt;
    cur_r        <= cur_nxt;
    res_stored_r <= res_stored_nxt;
    res_rvalid_r <= res_rvalid_nxt;
    res_entry_r  <= res_entry_nxt;
    if (state_r == ST_DONE && out_free) begin
      o_stored_r <= res_stored_r;
      o_occ_r    <= OCC_W'(fill_r);
      o_rvalid_r <= res_rvalid_r;
      o_entry_r  <= res_entry_r;
    end
  end

  a_kid_of_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIFT) |-> (kid_r == {node_r, 1'b1}))
    else $error("sift child index out of step with node");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && fill_r != $past(fill_r)) |-> (fill_r == $past(fill_r) + 1'b1))
    else $error("fill count moved by other than one");

  a_build_full: assert property (@(posedge clk) disable iff (!rst_n)
    build_r |-> (fill_r == FULL))
    else $error("heap build running on a store that is not full");

  a_read_not_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.read_valid) |-> !out_ch.stored)
    else $error("read result flagged as stored");

endmodule
